FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Clocked check that also holds while reset is asserted.
`define ASSERT_CLK(lbl, clk_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

FILE: rtl/core/gfd_pkg.sv
package gfd_pkg;

    // Frame bytes
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] CTRL_DPAD   = 8'hFF;
    localparam logic [7:0] CMD_REBOOT  = 8'h01;
    localparam logic [7:0] DPAD_MASK   = 8'h0F;

    localparam int PAYLOAD_LEN = 7;
    localparam int AXIS_COUNT  = 4;

    // Status flags of one result
    typedef struct packed {
        logic frame_accepted;
        logic checksum_bad;
        logic reboot_request;
    } gfd_flags_t;

    // Latched pad state
    typedef struct packed {
        logic [3:0]                  dpad;
        logic [15:0]                 buttons;
        logic [AXIS_COUNT-1:0][7:0]  axis;
    } gfd_held_t;

endpackage

FILE: rtl/core/gfd_parser.sv
module gfd_parser
    import gfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output gfd_flags_t flags_next,
    output gfd_held_t  held
);

    typedef enum logic [3:0] {
        POS_HUNT  = 4'd0,
        POS_SYNC2 = 4'd1,
        POS_PAY0  = 4'd2,
        POS_PAY1  = 4'd3,
        POS_PAY2  = 4'd4,
        POS_PAY3  = 4'd5,
        POS_PAY4  = 4'd6,
        POS_PAY5  = 4'd7,
        POS_PAY6  = 4'd8,
        POS_CHECK = 4'd9
    } pos_t;

    pos_t       pos_reg;
    pos_t       pos_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    gfd_held_t  held_reg;
    gfd_held_t  held_next;
    logic       store_we;
    logic [2:0] store_idx;

    // Payload bytes of the frame in flight; each is written before it is read
    logic [7:0] payload_store [PAYLOAD_LEN];

    assign store_idx = 3'(pos_reg - POS_PAY0);
    assign held      = held_reg;

    // Parser step for the byte being transferred
    always_comb
    begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        held_next  = held_reg;
        flags_next = '0;
        store_we   = 1'b0;
        unique case (pos_reg) inside
            POS_HUNT:
            begin
                pos_next = (rx_byte == SYNC_FIRST) ? POS_SYNC2 : POS_HUNT;
            end
            POS_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    pos_next = POS_PAY0;
                    xor_next = '0;
                end
                else
                begin
                    // repeated first sync byte keeps us waiting for the second
                    pos_next = (rx_byte == SYNC_FIRST) ? POS_SYNC2 : POS_HUNT;
                end
            end
            POS_PAY0, POS_PAY1, POS_PAY2, POS_PAY3, POS_PAY4, POS_PAY5, POS_PAY6:
            begin
                store_we = 1'b1;
                xor_next = xor_reg ^ rx_byte;
                pos_next = pos_t'(pos_reg + 4'd1);
            end
            POS_CHECK:
            begin
                pos_next = POS_HUNT;
                if (rx_byte == xor_reg)
                begin
                    if (payload_store[0] == CTRL_DPAD)
                    begin
                        // control frame: only the reboot command is acted on
                        flags_next.reboot_request = (payload_store[1] == CMD_REBOOT);
                    end
                    else
                    begin
                        held_next.dpad    = 4'(payload_store[0] & DPAD_MASK);
                        held_next.buttons = {payload_store[2], payload_store[1]};
                        held_next.axis[0] = payload_store[3];
                        held_next.axis[1] = payload_store[4];
                        held_next.axis[2] = payload_store[5];
                        held_next.axis[3] = payload_store[6];
                        flags_next.frame_accepted = 1'b1;
                    end
                end
                else
                begin
                    flags_next.checksum_bad = 1'b1;
                end
            end
            default:
            begin
                pos_next = POS_HUNT;
            end
        endcase
    end

    // Parse position, running check value and pad latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_HUNT;
            xor_reg  <= '0;
            held_reg <= '0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            xor_reg  <= xor_next;
            held_reg <= held_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (step && store_we)
        begin
            payload_store[store_idx] <= rx_byte;
        end
    end

endmodule

FILE: rtl/core/gamepad_frame_deframer.sv
// Gamepad frame deframer.
// Input channel: one received serial byte (rx_byte) per transfer, with
// in_valid / in_stall. Frames are 0xAA 0x55, seven payload bytes (dpad,
// button low, button high, left x, left y, right x, right y) and an XOR
// check byte.
// Output channel: one result per input byte, with out_valid / out_stall.
// It carries the frame flags and the latched pad state after that byte.
// Latency: a result appears the cycle after its byte is transferred.
// Throughput: one byte per cycle while no result is stalled; the parser step
// is a single pass from the parse state and payload registers into the result register.
// When the receiver stalls a waiting result, in_stall is raised in the same
// cycle and the result holds until it is taken; a byte is accepted in the
// cycle the result leaves.
// Reset: parser hunts for the first sync byte, pad latches clear to zero
// and no result is pending.
module gamepad_frame_deframer
    import gfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_accepted,
    output logic        checksum_bad,
    output logic        reboot_request,
    output logic [3:0]  held_dpad,
    output logic [15:0] held_buttons,
    output logic [7:0]  left_x,
    output logic [7:0]  left_y,
    output logic [7:0]  right_x,
    output logic [7:0]  right_y
);

    logic       out_valid_reg;
    gfd_flags_t flags_reg;
    gfd_flags_t flags_next;
    gfd_held_t  held;
    logic       in_xfer;

    // Input side is held only while a result waits on a stalled receiver
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    gfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_xfer),
        .rx_byte    (rx_byte),
        .flags_next (flags_next),
        .held       (held)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
            flags_reg     <= flags_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_accepted = flags_reg.frame_accepted;
    assign checksum_bad   = flags_reg.checksum_bad;
    assign reboot_request = flags_reg.reboot_request;
    // pad latches only move on a transfer, so they double as result fields
    assign held_dpad      = held.dpad;
    assign held_buttons   = held.buttons;
    assign left_x         = held.axis[0];
    assign left_y         = held.axis[1];
    assign right_x        = held.axis[2];
    assign right_y        = held.axis[3];

endmodule

FILE: rtl/core/gfd_checker.sv
`include "assert_macros.svh"

module gfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic        frame_accepted,
    input logic        checksum_bad,
    input logic        reboot_request,
    input logic [3:0]  held_dpad,
    input logic [15:0] held_buttons,
    input logic [7:0]  left_x,
    input logic [7:0]  left_y,
    input logic [7:0]  right_x,
    input logic [7:0]  right_y
);

    logic [51:0] pad_state;

    // All latched pad fields in one vector
    assign pad_state = {held_dpad, held_buttons, left_x, left_y, right_x, right_y};

    // At most one frame outcome per result
    `ASSERT_CLK_RST(a_one_outcome, clk, rst_n, out_valid |-> $countones({frame_accepted, checksum_bad, reboot_request}) <= 1, "more than one frame flag set")

    // Pad state moves only with a result that reports a good data frame
    `ASSERT_CLK_RST(a_latch_on_accept, clk, rst_n, !$stable(pad_state) |-> (out_valid && frame_accepted), "pad state changed without an accepted frame")

    // A stalled result stays valid with its accept and checksum flags held
    `ASSERT_CLK_RST(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(checksum_bad) && $stable(frame_accepted)), "stalled result changed")

    // A stalled input byte stays offered and unchanged
    `ASSERT_CLK_RST(a_in_hold, clk, rst_n, (in_valid && in_stall) |=> (in_valid && $stable(rx_byte)), "stalled input changed")

    // Input is never stalled while nothing waits at the output
    `ASSERT_CLK(a_stall_cause, clk, in_stall |-> (out_valid && out_stall), "input stalled without a pending result")

endmodule

bind gamepad_frame_deframer gfd_checker u_gfd_checker (.*);
